FILE: rtl/dpha_pkg.sv
// shared types and constants of the drop point hit aggregator
`timescale 1ns / 1ps
`default_nettype none

package dpha_pkg;

	localparam int DPHA_MAX_ENTRIES = 64;

	localparam int LOC_W      = 64;
	localparam int COUNT_W    = 32;
	localparam int LIMIT_W    = 7;
	localparam int DELAY_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [LIMIT_W-1:0] HIT_LIMIT_RST   = 7'd64;
	localparam logic [DELAY_W-1:0] DELAY_TICKS_RST = 16'd1000;

	localparam logic [CFG_IDX_W-1:0] CFG_HIT_LIMIT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 1'b1;

	localparam logic MODE_DROP = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_REP_RD,
		ST_REP_LD
	} dpha_state_t;

	typedef struct packed {
		logic load_loc;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic insert;
		logic inc_write;
		logic tick_dec;
		logic clear_table;
		logic out_load;
	} dpha_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_mode;
		logic armed;
		logic expire;
		logic used_zero;
		logic idx_end;
		logic full;
		logic match;
		logic last_idx;
		logic out_free;
	} dpha_status_t;

endpackage

`default_nettype wire

FILE: rtl/dpha_in_if.sv
// request channel carrying drop events and time ticks
`timescale 1ns / 1ps
`default_nettype none

interface dpha_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [63:0] location;

	modport source (output valid, output mode, output location, input ready);
	modport sink   (input valid, input mode, input location, output ready);
endinterface

`default_nettype wire

FILE: rtl/dpha_out_if.sv
// request channel carrying reported table entries
`timescale 1ns / 1ps
`default_nettype none

interface dpha_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] drop_location;
	logic [31:0] hit_count;
	logic        last_entry;

	modport source (output valid, output drop_location, output hit_count, output last_entry,
		input ready);
	modport sink   (input valid, input drop_location, input hit_count, input last_entry,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/dpha_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module dpha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dpha_ctrl.sv
// sequencer for search, insert, timer and report
`timescale 1ns / 1ps
`default_nettype none

module dpha_ctrl import dpha_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire dpha_status_t sts,
	output      logic         in_ready,
	output      dpha_cmd_t    cmd
);

	dpha_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sts.in_valid) begin
					if (sts.in_mode == MODE_DROP) begin
						state_d = ST_SRCH_RD;
					end else if (sts.armed && sts.expire && !sts.used_zero) begin
						state_d = ST_REP_RD;
					end
				end
			end
			ST_SRCH_RD: begin
				state_d = sts.idx_end ? ST_IDLE : ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				state_d = sts.match ? ST_IDLE : ST_SRCH_RD;
			end
			ST_REP_RD: begin
				state_d = ST_REP_LD;
			end
			ST_REP_LD: begin
				if (sts.out_free) begin
					state_d = sts.last_idx ? ST_IDLE : ST_REP_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (sts.in_valid) begin
					if (sts.in_mode == MODE_DROP) begin
						cmd.load_loc = 1'b1;
						cmd.idx_clr  = 1'b1;
					end else if (sts.armed) begin
						if (!sts.expire) begin
							cmd.tick_dec = 1'b1;
						end else if (sts.used_zero) begin
							cmd.clear_table = 1'b1;
						end else begin
							cmd.idx_clr = 1'b1;
						end
					end
				end
			end
			ST_SRCH_RD: begin
				if (sts.idx_end) begin
					cmd.insert = !sts.full;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			ST_SRCH_CMP: begin
				if (sts.match) begin
					cmd.inc_write = 1'b1;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_REP_RD: begin
				cmd.rd_en = 1'b1;
			end
			ST_REP_LD: begin
				if (sts.out_free) begin
					cmd.out_load    = 1'b1;
					cmd.idx_inc     = 1'b1;
					cmd.clear_table = sts.last_idx;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/dpha_datapath.sv
// entry tables, counters, timer, config registers and output register
`timescale 1ns / 1ps
`default_nettype none

module dpha_datapath import dpha_pkg::*; #(
	parameter int MAX_ENTRIES = DPHA_MAX_ENTRIES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dpha_cmd_t             cmd,
	output      dpha_status_t          sts,
	input  wire logic                  in_valid,
	input  wire logic                  in_mode,
	input  wire logic [LOC_W-1:0]      in_location,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic [LOC_W-1:0]      out_location,
	output      logic [COUNT_W-1:0]    out_count,
	output      logic                  out_last,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int UW = $clog2(MAX_ENTRIES + 1);

	logic [LIMIT_W-1:0] hit_limit_q;
	logic [DELAY_W-1:0] delay_ticks_q;
	logic [LOC_W-1:0]   loc_q;
	logic [UW-1:0]      idx_q;
	logic [UW-1:0]      used_q;
	logic               armed_q;
	logic [DELAY_W-1:0] ticks_q;
	logic               out_valid_q;
	logic [LOC_W-1:0]   out_loc_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic               out_last_q;

	logic [UW-1:0]      idx_nxt;
	logic [IW-1:0]      waddr;
	logic [LOC_W-1:0]   loc_rd;
	logic [COUNT_W-1:0] cnt_rd;
	logic [COUNT_W-1:0] cnt_sat;
	logic [COUNT_W-1:0] cnt_wdata;

	assign idx_nxt   = idx_q + UW'(1);
	assign waddr     = cmd.insert ? used_q[IW-1:0] : idx_q[IW-1:0];
	assign cnt_sat   = (cnt_rd == '1) ? cnt_rd : cnt_rd + COUNT_W'(1);
	assign cnt_wdata = cmd.insert ? COUNT_W'(1) : cnt_sat;

	dpha_ram #(.WIDTH(LOC_W), .DEPTH(MAX_ENTRIES)) u_loc_ram (
		.clk   (clk),
		.we    (cmd.insert),
		.waddr (waddr),
		.wdata (loc_q),
		.re    (cmd.rd_en),
		.raddr (idx_q[IW-1:0]),
		.rdata (loc_rd)
	);

	dpha_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_ENTRIES)) u_cnt_ram (
		.clk   (clk),
		.we    (cmd.insert || cmd.inc_write),
		.waddr (waddr),
		.wdata (cnt_wdata),
		.re    (cmd.rd_en),
		.raddr (idx_q[IW-1:0]),
		.rdata (cnt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_limit_q   <= HIT_LIMIT_RST;
			delay_ticks_q <= DELAY_TICKS_RST;
			idx_q         <= '0;
			used_q        <= '0;
			armed_q       <= 1'b0;
			ticks_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HIT_LIMIT:   hit_limit_q   <= cfg_data[LIMIT_W-1:0];
					CFG_DELAY_TICKS: delay_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_nxt;
			end
			if (cmd.clear_table) begin
				used_q  <= '0;
				armed_q <= 1'b0;
				ticks_q <= '0;
			end else if (cmd.insert) begin
				used_q <= used_q + UW'(1);
				if (!armed_q) begin
					armed_q <= 1'b1;
					ticks_q <= delay_ticks_q;
				end
			end else if (cmd.tick_dec) begin
				ticks_q <= ticks_q - DELAY_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_loc) begin
			loc_q <= in_location;
		end
		if (cmd.out_load) begin
			out_loc_q  <= loc_rd;
			out_cnt_q  <= cnt_rd;
			out_last_q <= (idx_nxt == used_q);
		end
	end

	always_comb begin
		sts.in_valid  = in_valid;
		sts.in_mode   = in_mode;
		sts.armed     = armed_q;
		sts.expire    = (ticks_q <= DELAY_W'(1));
		sts.used_zero = (used_q == '0);
		sts.idx_end   = (idx_q == used_q);
		sts.full      = (32'(used_q) >= 32'(MAX_ENTRIES)) || (32'(used_q) >= 32'(hit_limit_q));
		sts.match     = (loc_rd == loc_q);
		sts.last_idx  = (idx_nxt == used_q);
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign out_location = out_loc_q;
	assign out_count    = out_cnt_q;
	assign out_last     = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/drop_point_hit_aggregator_unit.sv
// Drop point hit aggregator: counts drop events per location and reports the table.
// Channels: events (sink) carries mode and location; mode 0 is a drop event,
// mode 1 a time tick. reports (source) carries drop_location, hit_count and
// last_entry, one request per held entry. Configuration is a write port
// (cfg_we, cfg_index, cfg_data): index 0 hit_limit, index 1 delay_ticks.
// Operation: a tick that starts no report run is handled in the idle state.
// A drop event scans the held entries one by one through the location memory,
// a read state and then a compare state per entry, and ends at a match or
// after the last held entry; each entry memory has a single read port, which
// sets that pace. A report run reads and loads each entry in turn, and events
// is not ready until the last entry has gone into the output register.
// Reset: the table is empty, the timer idle, hit_limit 64 and delay_ticks 1000;
// no clearing pass is needed.
// Stall: reports has an output register; a stalled receiver holds it and
// a report run pauses, while events is taken again once the run has loaded
// its final entry.
`timescale 1ns / 1ps
`default_nettype none

module drop_point_hit_aggregator_unit import dpha_pkg::*; #(
	parameter int MAX_ENTRIES = DPHA_MAX_ENTRIES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	dpha_in_if.sink                    events,
	dpha_out_if.source                 reports,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	dpha_cmd_t    cmd;
	dpha_status_t sts;

	dpha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.in_ready (events.ready),
		.cmd      (cmd)
	);

	dpha_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_valid     (events.valid),
		.in_mode      (events.mode),
		.in_location  (events.location),
		.out_valid    (reports.valid),
		.out_ready    (reports.ready),
		.out_location (reports.drop_location),
		.out_count    (reports.hit_count),
		.out_last     (reports.last_entry),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

endmodule

`default_nettype wire

FILE: tb/drop_point_hit_aggregator_unit_tb.sv
// self-checking testbench of the drop point hit aggregator, with a table tracker scoreboard
`timescale 1ns / 1ps

module drop_point_hit_aggregator_unit_tb import dpha_pkg::*;;

	localparam int HOLD_OFF       = 2 * DPHA_MAX_ENTRIES + 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 80;
	localparam int NO_IDLE_TAIL   = 40;

	typedef struct {
		logic [LOC_W-1:0]   location;
		logic [COUNT_W-1:0] count;
		logic               last;
	} table_entry_t;

	class drop_table_tracker;
		logic [LIMIT_W-1:0] hold_limit;
		logic [DELAY_W-1:0] report_delay;
		logic [LOC_W-1:0]   held_locs [DPHA_MAX_ENTRIES];
		logic [COUNT_W-1:0] held_counts [DPHA_MAX_ENTRIES];
		int unsigned        held_n;
		bit                 timer_running;
		logic [DELAY_W-1:0] ticks_left;
		table_entry_t       pending_entries [$];
		int                 mismatches;

		function new();
			hold_limit    = HIT_LIMIT_RST;
			report_delay  = DELAY_TICKS_RST;
			held_n        = 0;
			timer_running = 1'b0;
			ticks_left    = '0;
			mismatches    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_HIT_LIMIT)
				hold_limit = data[LIMIT_W-1:0];
			else if (idx == CFG_DELAY_TICKS)
				report_delay = data[DELAY_W-1:0];
		endfunction

		function void count_drop(logic [LOC_W-1:0] loc);
			int unsigned cap;
			cap = (hold_limit > DPHA_MAX_ENTRIES) ? DPHA_MAX_ENTRIES : hold_limit;
			for (int unsigned i = 0; i < held_n; i++) begin
				if (held_locs[i] == loc) begin
					if (held_counts[i] != '1)
						held_counts[i] = held_counts[i] + 1'b1;
					return;
				end
			end
			if (held_n >= cap)
				return;
			held_locs[held_n]   = loc;
			held_counts[held_n] = 1;
			held_n++;
			if (!timer_running) begin
				timer_running = 1'b1;
				ticks_left    = report_delay;
			end
		endfunction

		function void note_item(logic mode, logic [LOC_W-1:0] loc);
			table_entry_t e;
			if (mode == MODE_DROP) begin
				count_drop(loc);
			end else if (timer_running) begin
				if (ticks_left <= 1) begin
					for (int unsigned i = 0; i < held_n; i++) begin
						e.location = held_locs[i];
						e.count    = held_counts[i];
						e.last     = (i + 1 == held_n);
						pending_entries.push_back(e);
					end
					held_n        = 0;
					timer_running = 1'b0;
					ticks_left    = '0;
				end else begin
					ticks_left = ticks_left - 1'b1;
				end
			end
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_report(logic [LOC_W-1:0] loc, logic [COUNT_W-1:0] cnt, logic last);
			table_entry_t e;
			if (pending_entries.size() == 0) begin
				report_mismatch($sformatf("unexpected entry loc %h count %0d last %b",
					loc, cnt, last));
				return;
			end
			e = pending_entries.pop_front();
			if (loc !== e.location || cnt !== e.count || last !== e.last)
				report_mismatch($sformatf("got loc %h count %0d last %b, want %h %0d %b",
					loc, cnt, last, e.location, e.count, e.last));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit                    idling;
	int                    stall_left;
	int                    quiet_cycles;
	int                    rand_items;
	drop_table_tracker     sb;

	dpha_in_if  ev ();
	dpha_out_if rep ();

	drop_point_hit_aggregator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (ev),
		.reports   (rep),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (rep.valid && rep.ready)
			sb.check_report(rep.drop_location, rep.hit_count, rep.last_entry);
		if (!idling) begin
			rep.ready <= 1'b1;
		end else if (stall_left != 0) begin
			rep.ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			rep.ready  <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			rep.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((ev.valid && ev.ready) || (rep.valid && rep.ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_event(input logic mode, input logic [LOC_W-1:0] loc);
		if (idling && $urandom_range(0, 3) == 0) begin
			ev.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		ev.valid    <= 1'b1;
		ev.mode     <= mode;
		ev.location <= loc;
		do @(posedge clk); while (!ev.ready);
		sb.note_item(mode, loc);
	endtask

	task automatic settle();
		ev.valid <= 1'b0;
		while (sb.pending_entries.size() != 0) @(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic configure(input bit wr_limit, input logic [LIMIT_W-1:0] limit,
		input bit wr_delay, input logic [DELAY_W-1:0] delay);
		logic [CFG_DATA_W-1:0] d;
		if (wr_limit) begin
			d = CFG_DATA_W'($urandom);
			d[LIMIT_W-1:0] = limit;
			cfg_we    <= 1'b1;
			cfg_index <= CFG_HIT_LIMIT;
			cfg_data  <= d;
			@(posedge clk);
			sb.write_reg(CFG_HIT_LIMIT, d);
		end
		if (wr_delay) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_DELAY_TICKS;
			cfg_data  <= delay;
			@(posedge clk);
			sb.write_reg(CFG_DELAY_TICKS, delay);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic flush_timer();
		while (sb.timer_running) send_event(MODE_TICK, {$urandom, $urandom});
	endtask

	task automatic run_phase(input logic [LIMIT_W-1:0] limit, input logic [DELAY_W-1:0] delay,
		input int pool_n, input int n_items, input int tick_one_in, input bit in_order,
		input bit flush_at_end);
		logic [LOC_W-1:0] pool [0:79];
		int               k;
		settle();
		configure(1'b1, limit, 1'b1, delay);
		for (k = 0; k < pool_n; k++) pool[k] = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0)
			pool[0] = '0;
		for (k = 0; k < n_items; k++) begin
			if (tick_one_in != 0 && $urandom_range(1, tick_one_in) == 1)
				send_event(MODE_TICK, {$urandom, $urandom});
			else if (in_order)
				send_event(MODE_DROP, pool[k % pool_n]);
			else
				send_event(MODE_DROP, pool[$urandom_range(0, pool_n - 1)]);
		end
		if (flush_at_end)
			flush_timer();
	endtask

	initial begin
		logic [LOC_W-1:0]   d0, d1, d2, d3;
		logic [LIMIT_W-1:0] lim;
		logic [DELAY_W-1:0] dly;
		int                 n;
		bit                 long_done, wide_done;
		sb           = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		ev.valid     = 1'b0;
		ev.mode      = MODE_DROP;
		ev.location  = '0;
		rep.ready    = 1'b0;
		idling       = 1'b1;
		stall_left   = 0;
		quiet_cycles = 0;
		rand_items   = 0;
		long_done    = 1'b0;
		wide_done    = 1'b0;
		d0 = {$urandom, $urandom};
		d1 = {$urandom, $urandom};
		d2 = {$urandom, $urandom};
		d3 = {$urandom, $urandom};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick on an idle timer
		send_event(MODE_TICK, '1);
		settle();
		configure(1'b1, 7'd3, 1'b1, 16'd2);
		send_event(MODE_DROP, '0);
		send_event(MODE_DROP, '1);
		send_event(MODE_DROP, '0);
		send_event(MODE_DROP, 64'hA5A5_A5A5_A5A5_A5A5);
		send_event(MODE_DROP, 64'h5A5A_5A5A_5A5A_5A5A);
		send_event(MODE_TICK, 64'h5A5A_5A5A_5A5A_5A5A);
		send_event(MODE_TICK, '0);
		send_event(MODE_TICK, '0);
		// zero limit never arms, zero delay
		settle();
		configure(1'b1, 7'd0, 1'b1, 16'd0);
		send_event(MODE_DROP, d0);
		send_event(MODE_TICK, d0);
		settle();
		configure(1'b1, 7'd5, 1'b0, '0);
		send_event(MODE_DROP, d0);
		send_event(MODE_TICK, d1);
		// limit lowered below fill
		settle();
		configure(1'b1, 7'd4, 1'b1, 16'd5);
		send_event(MODE_DROP, d0);
		send_event(MODE_DROP, d1);
		send_event(MODE_DROP, d2);
		send_event(MODE_DROP, d3);
		settle();
		configure(1'b1, 7'd2, 1'b0, '0);
		send_event(MODE_DROP, d1);
		send_event(MODE_DROP, ~d1);
		flush_timer();

		while (rand_items < RANDOM_ITEMS) begin
			if (rand_items >= RANDOM_ITEMS - NO_IDLE_TAIL)
				idling = 1'b0;
			case ($urandom_range(0, 5))
				0: lim = 7'd1;
				1: lim = 7'd64;
				2: lim = 7'd127;
				5: lim = LIMIT_W'($urandom_range(1, 127));
				default: lim = LIMIT_W'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 4))
				0: dly = 16'd1;
				1: dly = 16'd0;
				default: dly = DELAY_W'($urandom_range(1, 10));
			endcase
			n = $urandom_range(8, 30);
			run_phase(lim, dly, $urandom_range(1, (lim > 17) ? 20 : lim + 3), n, 4, 1'b0,
				$urandom_range(0, 3) != 0);
			rand_items += n;
			if (!long_done && rand_items > 30) begin
				long_done = 1'b1;
				run_phase(7'd8, 16'd30, 3, 3, 0, 1'b1, 1'b1);
			end
			if (!wide_done && rand_items > 60) begin
				wide_done = 1'b1;
				// more distinct locations than the table holds
				run_phase(7'd127, 16'd1, 72, 80, 0, 1'b1, 1'b1);
			end
		end
		flush_timer();
		settle();
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
rtl/dpha_pkg.sv
rtl/dpha_in_if.sv
rtl/dpha_out_if.sv
rtl/dpha_ram.sv
rtl/dpha_ctrl.sv
rtl/dpha_datapath.sv
rtl/drop_point_hit_aggregator_unit.sv
tb/drop_point_hit_aggregator_unit_tb.sv
